[sv/sbm_pkg.sv]
// Shared types, register codes and transfer tables for the sRGB box mipmap generator.
package sbm_pkg;

	// One level-0 pixel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} sbm_in_t;

	// One filtered pixel of a lower level
	typedef struct packed {
		logic [3:0]  mip_level;
		logic [10:0] pos_x;
		logic [10:0] pos_y;
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [7:0]  out_alpha;
		logic        last_for_input;
		logic        chain_done;
	} sbm_out_t;

	// Register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SRGB   = 2'd2;

	typedef logic [15:0] lin_tab_t [256];
	typedef logic [15:0] thr_tab_t [255];

	// Fifth power of a Q30 value
	function automatic longint unsigned pow5_q30(longint unsigned r);
		longint unsigned r2;
		longint unsigned r4;
		r2 = (r * r) >> 30;
		r4 = (r2 * r2) >> 30;
		return (r4 * r) >> 30;
	endfunction

	// Linear value of code k/510 as a 16-bit fraction
	function automatic logic [15:0] decode_half(int unsigned k);
		longint unsigned kk;
		longint unsigned t;
		longint unsigned t2;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned y;
		longint unsigned lin;
		kk = 64'(k);
		if (kk * 64'd100000 <= 64'd2062950)
			return 16'((64'd13107000 * kk + 64'd658920) / 64'd1317840);
		t = ((64'd1000 * kk + 64'd28050) << 30) / 64'd538050;
		t2 = (t * t) >> 30;
		lo = 64'd0;
		hi = 64'd1 << 30;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			if (pow5_q30(mid) <= t2) lo = mid;
			else hi = mid - 64'd1;
		end
		y = (t2 * lo) >> 30;
		lin = (y * 64'd65535 + (64'd1 << 29)) >> 30;
		if (lin > 64'd65535) lin = 64'd65535;
		return 16'(lin);
	endfunction

	function automatic lin_tab_t build_dec();
		lin_tab_t tab;
		for (int c = 0; c < 256; c++) tab[c] = decode_half(2 * c);
		return tab;
	endfunction

	function automatic thr_tab_t build_thr();
		thr_tab_t tab;
		for (int c = 0; c < 255; c++) tab[c] = decode_half(2 * c + 1);
		return tab;
	endfunction

	// Decode table and encode thresholds (midpoints between codes)
	localparam lin_tab_t DEC_TAB = build_dec();
	localparam thr_tab_t THR_TAB = build_thr();

endpackage

[sv/sbm_ram.sv]
// Generic single-port-write, registered-read RAM.
module sbm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[sv/srgb_box_mipmap_generator.sv]
// Top level of the sRGB 2x2 box-filter mip chain generator.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-------------------------------
//  in      | input     | in_valid/ready   | sbm_in_t, one level-0 pixel
//  out     | output    | out_valid/ready  | sbm_out_t, one lower-level pixel
//  apb     | config    | psel/penable     | width, height, srgb mode
//
// One pixel is taken, then the levels are walked one after another; in_ready
// is low until the walk ends. Each level passes an evaluate state; a level
// that completes a pixel adds up to two row-store reads, a sum step per
// channel plus eight encode-search steps per channel in sRGB mode, and a
// close state. The walk stalls while a finished pixel waits behind a full
// output register. Reset needs no clearing pass.
module srgb_box_mipmap_generator import sbm_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_LEVELS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sbm_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output sbm_out_t    out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CAP   = (MAX_WIDTH < (1 << MAX_LEVELS)) ? MAX_WIDTH : (1 << MAX_LEVELS);
	localparam int DW    = $clog2(CAP + 1);
	localparam int DEPTH = 2 * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(MAX_LEVELS + 1);
	localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RD1,
		ST_RD2,
		ST_SUM,
		ST_SRCH,
		ST_CLOSE
	} state_t;

	state_t        state_q;
	logic [12:0]   width_q;
	logic [12:0]   height_q;
	logic          srgb_q;
	logic [DW-1:0] col_q [MAX_LEVELS];
	logic [DW-1:0] row_q [MAX_LEVELS];
	logic [31:0]   pend_q [MAX_LEVELS];
	logic [SW-1:0] lvl_q;
	logic [AW-1:0] base_q;
	logic [DW-1:0] x_q;
	logic [DW-1:0] y_q;
	logic [31:0]   pix_q;
	logic [31:0]   op_a_q;
	logic [31:0]   op_b_q;
	logic [31:0]   op_c_q;
	logic [31:0]   res_q;
	logic [1:0]    ch_q;
	logic [15:0]   lvl_lin_q;
	logic [7:0]    cnt_q;
	logic [2:0]    bit_q;
	logic          hold_q;
	sbm_out_t      hold_data_q;
	logic          out_valid_q;
	sbm_out_t      out_q;

	logic [DW-1:0] w0, h0, w_cur, h_cur, x_cur, y_cur;
	logic [SW-1:0] lvl_nxt;
	logic [LW-1:0] lidx;
	logic          wide, tall, stop, wr_left, wr_row, produce, slot_free, go, cfg_wr;
	logic          rel;
	sbm_out_t      rel_data;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_rdata;
	logic [7:0]    a8, b8, c8, d8, try_code, cnt_nxt;
	logic [17:0]   lin_sum;
	logic [9:0]    raw_sum;
	logic [15:0]   lin_avg;

	// Dimension of a level: halve per level, never below one
	function automatic logic [DW-1:0] dim_at(logic [DW-1:0] d0, logic [SW-1:0] lv);
		logic [DW-1:0] v;
		v = d0 >> lv;
		return (v == '0) ? DW'(1) : v;
	endfunction

	// Clamp the level-0 size to the supported range
	always_comb begin
		if (width_q == '0) w0 = DW'(1);
		else if (32'(width_q) > CAP) w0 = DW'(CAP);
		else w0 = DW'(width_q);
		if (height_q == '0) h0 = DW'(1);
		else if (32'(height_q) > CAP) h0 = DW'(CAP);
		else h0 = DW'(height_q);
	end

	// Current level decode
	assign lvl_nxt   = lvl_q + SW'(1);
	assign lidx      = lvl_q[LW-1:0];
	assign w_cur     = dim_at(w0, lvl_q);
	assign h_cur     = dim_at(h0, lvl_q);
	assign x_cur     = col_q[lidx];
	assign y_cur     = row_q[lidx];
	assign wide      = w_cur > DW'(1);
	assign tall      = h_cur > DW'(1);
	assign stop      = (lvl_q == SW'(MAX_LEVELS)) || (!wide && !tall);
	assign wr_left   = wide && !x_cur[0];
	assign wr_row    = tall && !y_cur[0];
	assign produce   = !stop && !wr_left && !wr_row;
	assign slot_free = !out_valid_q || out_ready;
	assign go        = (state_q == ST_EVAL) && (!hold_q || slot_free);
	assign rel       = go && hold_q;
	assign cfg_wr    = psel && penable && pwrite;

	// Mark the held pixel as last when no further level produces
	always_comb begin
		rel_data = hold_data_q;
		rel_data.last_for_input = !produce;
	end

	// Row store access
	assign ram_we    = go && !stop && wr_row;
	assign ram_waddr = AW'(32'(base_q) + 32'(x_cur));
	always_comb begin
		if (state_q == ST_RD1) ram_raddr = AW'(32'(base_q) + 32'(x_q));
		else if (wide && tall) ram_raddr = AW'(32'(base_q) + 32'(x_cur) - 32'd1);
		else ram_raddr = base_q;
	end

	sbm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_row_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (pix_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Shared filter unit: one channel sum, one encode-search step
	assign a8       = op_a_q[{ch_q, 3'b000} +: 8];
	assign b8       = op_b_q[{ch_q, 3'b000} +: 8];
	assign c8       = op_c_q[{ch_q, 3'b000} +: 8];
	assign d8       = pix_q[{ch_q, 3'b000} +: 8];
	assign lin_sum  = 18'(DEC_TAB[a8]) + 18'(DEC_TAB[b8]) + 18'(DEC_TAB[c8])
		+ 18'(DEC_TAB[d8]);
	assign raw_sum  = 10'(a8) + 10'(b8) + 10'(c8) + 10'(d8);
	assign lin_avg  = 16'((lin_sum + 18'd2) >> 2);
	assign try_code = cnt_q | (8'd1 << bit_q);
	assign cnt_nxt  = (THR_TAB[try_code - 8'd1] <= lvl_lin_q) ? try_code : cnt_q;

	// Left-neighbor store per level
	always_ff @(posedge clk) begin
		if (go && !stop && wr_left) pend_q[lidx] <= pix_q;
	end

	// Sequencer, level positions, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= 13'd1;
			height_q    <= 13'd1;
			srgb_q      <= 1'b0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
			lvl_q       <= '0;
			base_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			pix_q       <= '0;
			op_a_q      <= '0;
			op_b_q      <= '0;
			op_c_q      <= '0;
			res_q       <= '0;
			ch_q        <= '0;
			lvl_lin_q   <= '0;
			cnt_q       <= '0;
			bit_q       <= '0;
			hold_q      <= 1'b0;
			hold_data_q <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// Drop the output once taken
			if (out_valid_q && out_ready && !rel) out_valid_q <= 1'b0;

			// Register writes restart the frame
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_WIDTH: width_q <= pwdata[12:0];
					REG_HEIGHT: height_q <= pwdata[12:0];
					REG_SRGB: srgb_q <= pwdata[0];
					default: ;
				endcase
				if (paddr[3:2] inside {REG_WIDTH, REG_HEIGHT, REG_SRGB}) begin
					for (int i = 0; i < MAX_LEVELS; i++) begin
						col_q[i] <= '0;
						row_q[i] <= '0;
					end
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pix_q   <= {in_data.alpha, in_data.blue, in_data.green, in_data.red};
						lvl_q   <= '0;
						base_q  <= '0;
						hold_q  <= 1'b0;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (go) begin
						// Release the previous level's pixel
						if (hold_q) begin
							out_valid_q <= 1'b1;
							out_q <= rel_data;
							hold_q <= 1'b0;
						end
						// Advance this level's position
						if (!stop) begin
							if (32'(x_cur) + 32'd1 >= 32'(w_cur)) begin
								col_q[lidx] <= '0;
								row_q[lidx] <= (32'(y_cur) + 32'd1 >= 32'(h_cur)) ? '0
									: y_cur + DW'(1);
							end else begin
								col_q[lidx] <= x_cur + DW'(1);
							end
						end
						x_q <= x_cur;
						y_q <= y_cur;
						ch_q <= '0;
						if (!produce) begin
							state_q <= ST_IDLE;
						end else if (wide && !tall) begin
							op_a_q  <= pend_q[lidx];
							op_b_q  <= pix_q;
							op_c_q  <= pend_q[lidx];
							state_q <= ST_SUM;
						end else begin
							state_q <= ST_RD1;
						end
					end
				end
				ST_RD1: begin
					op_a_q <= ram_rdata;
					if (wide) begin
						op_c_q  <= pend_q[lidx];
						state_q <= ST_RD2;
					end else begin
						op_b_q  <= ram_rdata;
						op_c_q  <= pix_q;
						state_q <= ST_SUM;
					end
				end
				ST_RD2: begin
					op_b_q  <= ram_rdata;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (srgb_q) begin
						lvl_lin_q <= {lin_avg[15:4], 4'h8};
						cnt_q     <= '0;
						bit_q     <= 3'd7;
						state_q   <= ST_SRCH;
					end else begin
						res_q[{ch_q, 3'b000} +: 8] <= 8'((raw_sum + 10'd2) >> 2);
						ch_q    <= ch_q + 2'd1;
						state_q <= (ch_q == 2'd3) ? ST_CLOSE : ST_SUM;
					end
				end
				ST_SRCH: begin
					// Build the code one bit a step against the thresholds
					cnt_q <= cnt_nxt;
					bit_q <= bit_q - 3'd1;
					if (bit_q == 3'd0) begin
						res_q[{ch_q, 3'b000} +: 8] <= cnt_nxt;
						ch_q    <= ch_q + 2'd1;
						state_q <= (ch_q == 2'd3) ? ST_CLOSE : ST_SUM;
					end
				end
				ST_CLOSE: begin
					hold_q <= 1'b1;
					hold_data_q.mip_level      <= 4'(32'(lvl_q) + 32'd1);
					hold_data_q.pos_x          <= 11'(32'(x_q) >> 1);
					hold_data_q.pos_y          <= 11'(32'(y_q) >> 1);
					hold_data_q.out_red        <= res_q[7:0];
					hold_data_q.out_green      <= res_q[15:8];
					hold_data_q.out_blue       <= res_q[23:16];
					hold_data_q.out_alpha      <= res_q[31:24];
					hold_data_q.last_for_input <= 1'b0;
					hold_data_q.chain_done     <= (dim_at(w0, lvl_nxt) == DW'(1))
						&& (dim_at(h0, lvl_nxt) == DW'(1));
					pix_q   <= res_q;
					base_q  <= AW'(32'(base_q) + 32'(w_cur));
					lvl_q   <= lvl_nxt;
					state_q <= ST_EVAL;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[3:2])
			REG_WIDTH: prdata = {19'd0, width_q};
			REG_HEIGHT: prdata = {19'd0, height_q};
			REG_SRGB: prdata = {31'd0, srgb_q};
			default: prdata = '0;
		endcase
	end

	assign pready    = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[sv/sbm_checker.sv]
// Port-level checks for the sRGB box mipmap generator, bound to the top level.
module sbm_checker import sbm_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input sbm_out_t out_data
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Take one pixel at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after a request");

	// Stay busy while more results of the current pixel are due
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_for_input |-> !in_ready)
		else $error("ready before last result");

	// The final level closes the pixel's results
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.chain_done |-> out_data.last_for_input)
		else $error("chain end not last");

endmodule

bind srgb_box_mipmap_generator sbm_checker u_sbm_checker (.*);
